@@ rtl/unicycle_pose_integrator_unit_defines.svh @@
// Assertion helpers for the RTL.
`ifndef UNICYCLE_POSE_INTEGRATOR_UNIT_DEFINES_SVH
`define UNICYCLE_POSE_INTEGRATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define UPI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("unicycle pose integrator check failed");
// Next-cycle implication.
`define UPI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("unicycle pose integrator check failed");
`else
`define UPI_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define UPI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/upi_pkg.sv @@
`timescale 1ns / 1ps

package upi_pkg;

  // Rotation stages, limited to the length of the arctangent table.
  localparam int CORDIC_STAGES = 16;
  localparam int NSTAGES = (CORDIC_STAGES < 30) ? CORDIC_STAGES : 30;
  localparam int ITER_W = (NSTAGES > 1) ? $clog2(NSTAGES) : 1;

  // Datapath widths: vector in Q16.24 with growth headroom, signed angle.
  localparam int CW = 40;
  localparam int ZW = 34;

  // 1/K in Q0.32.
  localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;

  localparam logic [24:0] STEP_LENGTH_RST    = 25'd6554;
  localparam logic [31:0] HEADING_STEP_RST   = 32'd0;
  localparam logic [15:0] STEPS_PER_PATH_RST = 16'd10;

  // Register indexes.
  localparam logic [1:0] CFG_STEP_LENGTH    = 2'd0;
  localparam logic [1:0] CFG_HEADING_STEP   = 2'd1;
  localparam logic [1:0] CFG_STEPS_PER_PATH = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [24:0] step_length;
    logic [31:0] heading_step;
    logic [15:0] steps_per_path;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [24:0] len;
    logic [31:0] ang;
  } rot_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] cos_v;
    logic [31:0] sin_v;
  } rot_rsp_t;

  // round(atan(2^-i) * 2^32 / 2pi)
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/unicycle_pose_integrator_unit.sv @@
`timescale 1ns / 1ps
`include "unicycle_pose_integrator_unit_defines.svh"
// Unicycle pose integrator, midpoint dead reckoning.
// Input stream (s_axis): one transfer per tick; tdata[0] is restart, which
// clears pose and step count before the tick is applied.
// Output stream (m_axis): one transfer per tick; tdata carries new x, new y
// (signed Q16.16, wrapping) and the heading (binary angle); tlast marks the
// tick that reaches steps_per_path, after which the count starts over.
// Config channel: write index 0 step_length, 1 heading_step, 2 steps_per_path;
// other indexes are dropped. Writes belong to idle periods only.
// From input transfer to output valid: multiply on the transfer edge, then
// load, 16 CORDIC iterations of the one shared add/shift unit, rounding,
// hand-over to the sequencer, and the update, which waits on a stalled output.
// Ticks are taken one at a time: tready returns in the same cycle as output
// valid, once the result is registered, as the shared rotation unit and the
// pose feedback hold the next tick. tready is high only when no tick is in flight.
// Reset clears pose, count and output valid; registers return to their
// defaults. A stalled receiver holds the result in the output register; the
// next tick may enter and waits at the pose update until that register frees.
module unicycle_pose_integrator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [0] restart, [7:1] zero
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,  // [31:0] pos_x, [63:32] pos_y, [95:64] heading
  output logic        m_axis_tlast,  // last
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  upi_pkg::cfg_t     cfg;
  upi_pkg::rot_req_t rot_req;
  upi_pkg::rot_rsp_t rot_rsp;
  upi_pkg::state_e   state_q, state_d;

  // pose and path counter
  logic [31:0] x_acc_q, y_acc_q, head_acc_q;
  logic [15:0] count_q;

  // output register
  logic        tvalid_q;
  logic [95:0] tdata_q;
  logic        tlast_q;

  logic        in_xfer, emit_go, restart;
  logic [31:0] half_step, head_base;
  logic [31:0] x_new, y_new, head_new;
  logic [15:0] count_next;
  logic        last_hit;

  upi_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  upi_cordic u_cordic (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (rot_req),
    .rsp_o (rot_rsp)
  );

  assign restart = s_axis_tdata[0];

  // midpoint angle: heading plus half the step, floor halving
  assign half_step = {cfg.heading_step[31], cfg.heading_step[31:1]};
  assign head_base = restart ? 32'd0 : head_acc_q;

  // pose update, applied once the rotation has finished
  assign x_new      = x_acc_q - rot_rsp.sin_v;
  assign y_new      = y_acc_q + rot_rsp.cos_v;
  assign head_new   = head_acc_q + cfg.heading_step;
  assign count_next = count_q + 16'd1;
  assign last_hit   = (count_next == cfg.steps_per_path);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      upi_pkg::ST_IDLE:   if (s_axis_tvalid) state_d = upi_pkg::ST_ROTATE;
      upi_pkg::ST_ROTATE: if (rot_rsp.done)  state_d = upi_pkg::ST_EMIT;
      upi_pkg::ST_EMIT:   if (!tvalid_q || m_axis_tready) state_d = upi_pkg::ST_IDLE;
      default:            state_d = upi_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    emit_go       = 1'b0;
    unique case (state_q)
      upi_pkg::ST_IDLE:   s_axis_tready = 1'b1;
      upi_pkg::ST_ROTATE: ;
      upi_pkg::ST_EMIT:   emit_go = !tvalid_q || m_axis_tready;
      default:            ;
    endcase
  end

  assign in_xfer = s_axis_tvalid && s_axis_tready;

  assign rot_req.start = in_xfer;
  assign rot_req.len   = cfg.step_length;
  assign rot_req.ang   = head_base + half_step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= upi_pkg::ST_IDLE;
      x_acc_q    <= '0;
      y_acc_q    <= '0;
      head_acc_q <= '0;
      count_q    <= '0;
      tvalid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer && restart) begin
        x_acc_q    <= '0;
        y_acc_q    <= '0;
        head_acc_q <= '0;
        count_q    <= '0;
      end else if (emit_go) begin
        x_acc_q    <= x_new;
        y_acc_q    <= y_new;
        head_acc_q <= head_new;
        count_q    <= last_hit ? 16'd0 : count_next;
      end
      if (emit_go) begin
        tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      tdata_q <= {head_new, y_new, x_new};
      tlast_q <= last_hit;
    end
  end

  assign m_axis_tvalid = tvalid_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tlast  = tlast_q;

  `UPI_ASSERT_NEXT(a_xfer_starts_rotation, clk_i, rst_ni, in_xfer, state_q == upi_pkg::ST_ROTATE && rot_rsp.busy)
  `UPI_ASSERT_NOW(a_done_only_rotating, clk_i, rst_ni, rot_rsp.done, state_q == upi_pkg::ST_ROTATE)
  `UPI_ASSERT_NOW(a_unit_quiet_when_idle, clk_i, rst_ni, state_q == upi_pkg::ST_IDLE, !rot_rsp.busy && !rot_rsp.done)
  `UPI_ASSERT_NEXT(a_emit_loads_output, clk_i, rst_ni, emit_go, tvalid_q && state_q == upi_pkg::ST_IDLE)

endmodule

@@ rtl/upi_cfg.sv @@
`timescale 1ns / 1ps

module upi_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  output upi_pkg::cfg_t     cfg_o
);

  upi_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_length    <= upi_pkg::STEP_LENGTH_RST;
      cfg_q.heading_step   <= upi_pkg::HEADING_STEP_RST;
      cfg_q.steps_per_path <= upi_pkg::STEPS_PER_PATH_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        upi_pkg::CFG_STEP_LENGTH:    cfg_q.step_length    <= cfg_data_i[24:0];
        upi_pkg::CFG_HEADING_STEP:   cfg_q.heading_step   <= cfg_data_i;
        upi_pkg::CFG_STEPS_PER_PATH: cfg_q.steps_per_path <= cfg_data_i[15:0];
        default: ; // unmapped index, dropped
      endcase
    end
  end

endmodule

@@ rtl/upi_cordic.sv @@
`timescale 1ns / 1ps

module upi_cordic (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  upi_pkg::rot_req_t   req_i,
  output upi_pkg::rot_rsp_t   rsp_o
);

  localparam logic [upi_pkg::ITER_W-1:0] ITER_LAST = upi_pkg::ITER_W'(upi_pkg::NSTAGES - 1);

  // control
  logic                       load_q, run_q, fin_q, done_q;
  logic [upi_pkg::ITER_W-1:0] iter_q;
  logic                       iter_last;

  // datapath
  logic [56:0]                prod_q;
  logic                       flip_q;
  logic signed [upi_pkg::ZW-1:0] z_q;
  logic signed [upi_pkg::CW-1:0] x_q, y_q;
  logic [31:0]                cos_q, sin_q;

  logic                       flip_in;
  logic [31:0]                ang_fold;
  logic [57:0]                x0_sum;
  logic signed [upi_pkg::CW-1:0] dx, dy, xf, yf, xr, yr;
  logic signed [upi_pkg::ZW-1:0] at;

  assign iter_last = (iter_q == ITER_LAST);

  // second and third quadrants are turned by half a turn, results negated
  assign flip_in  = req_i.ang[31] ^ req_i.ang[30];
  assign ang_fold = flip_in ? (req_i.ang ^ 32'h80000000) : req_i.ang;

  assign x0_sum = {1'b0, prod_q} + 58'(1 << 23);

  assign dx = y_q >>> iter_q;
  assign dy = x_q >>> iter_q;
  assign at = $signed({{(upi_pkg::ZW-32){1'b0}}, upi_pkg::atan_lut(5'(iter_q))});

  assign xf = flip_q ? -x_q : x_q;
  assign yf = flip_q ? -y_q : y_q;
  assign xr = (xf + upi_pkg::CW'(128)) >>> 8;
  assign yr = (yf + upi_pkg::CW'(128)) >>> 8;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= 1'b0;
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      load_q <= req_i.start;
      fin_q  <= run_q && iter_last;
      done_q <= fin_q;
      if (load_q) begin
        run_q  <= 1'b1;
        iter_q <= '0;
      end else if (run_q) begin
        run_q  <= !iter_last;
        iter_q <= iter_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      prod_q <= 57'(req_i.len) * 57'(upi_pkg::GAIN_Q32);
      flip_q <= flip_in;
      z_q    <= upi_pkg::ZW'($signed(ang_fold));
    end else if (run_q) begin
      z_q <= z_q[upi_pkg::ZW-1] ? (z_q + at) : (z_q - at);
    end
    if (load_q) begin
      x_q <= $signed({{(upi_pkg::CW-34){1'b0}}, x0_sum[57:24]});
      y_q <= '0;
    end else if (run_q) begin
      if (!z_q[upi_pkg::ZW-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
      end
    end
    if (fin_q) begin
      cos_q <= xr[31:0];
      sin_q <= yr[31:0];
    end
  end

  assign rsp_o.busy  = load_q | run_q | fin_q;
  assign rsp_o.done  = done_q;
  assign rsp_o.cos_v = cos_q;
  assign rsp_o.sin_v = sin_q;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int          HALF_PERIOD  = 10;
  localparam int          SETTLE_TICKS = 25;    // margin past the block latency
  localparam int          STALL_LIMIT  = 4000;  // cycles without any transfer
  localparam int          RANDOM_TICKS = 1000;
  localparam logic [1:0]  CFG_SPARE    = 2'd3;  // no register behind it
  localparam logic [31:0] ROT_GAIN     = 32'h9B74EDA8;

  typedef struct {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] heading;
    logic        last;
  } pose_t;

  // Arctangent of 2^-i as a binary angle, 2^32 per turn.
  logic [31:0] atan_turn [30] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = 2'd0;
  logic [31:0] cfg_data_i    = 32'h0;

  // Local copy of the registers and pose, updated on each accepted transfer.
  logic [24:0] step_len     = upi_pkg::STEP_LENGTH_RST;
  logic [31:0] turn_step    = upi_pkg::HEADING_STEP_RST;
  logic [15:0] path_ticks   = upi_pkg::STEPS_PER_PATH_RST;
  logic [31:0] x_pos        = '0;
  logic [31:0] y_pos        = '0;
  logic [31:0] heading_pos  = '0;
  logic [15:0] tick_count   = '0;

  pose_t expected_poses [$];
  pose_t want_pose;
  int    mismatches  = 0;
  int    idle_cycles = 0;
  int    tx_idle_pct = 26;
  int    rx_idle_pct = 47;

  unicycle_pose_integrator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Rotates (len/K, 0) by a binary angle; returns len*cos and len*sin in Q16.16.
  function automatic void rotate_step(input logic [24:0] len, input logic [31:0] ang,
                                      output longint cos_q, output longint sin_q);
    logic        flip;
    logic [31:0] folded;
    logic [63:0] scaled;
    longint      vx, vy, vz, dx, dy;
    flip   = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
    folded = flip ? (ang ^ 32'h80000000) : ang;
    vz     = {{32{folded[31]}}, folded};
    scaled = 64'(len) * 64'(ROT_GAIN) + 64'h800000;
    vx     = scaled >> 24;
    vy     = 0;
    for (int i = 0; i < upi_pkg::NSTAGES; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vz >= 0) begin
        vx = vx - dx;
        vy = vy + dy;
        vz = vz - longint'({32'h0, atan_turn[i]});
      end else begin
        vx = vx + dx;
        vy = vy - dy;
        vz = vz + longint'({32'h0, atan_turn[i]});
      end
    end
    if (flip) begin
      vx = -vx;
      vy = -vy;
    end
    cos_q = (vx + 128) >>> 8;
    sin_q = (vy + 128) >>> 8;
  endfunction

  // Midpoint dead reckoning for one tick.
  function automatic pose_t advance_pose(input logic restart);
    pose_t       p;
    logic [31:0] mid;
    logic [15:0] next_count;
    longint      c, s;
    if (restart) begin
      x_pos       = '0;
      y_pos       = '0;
      heading_pos = '0;
      tick_count  = '0;
    end
    // floor halving of the signed step
    mid = heading_pos + {turn_step[31], turn_step[31:1]};
    rotate_step(step_len, mid, c, s);
    x_pos       = x_pos - c[31:0] + c[31:0] - s[31:0];
    y_pos       = y_pos + c[31:0];
    heading_pos = heading_pos + turn_step;
    next_count  = tick_count + 16'd1;
    p.last      = (next_count == path_ticks);
    tick_count  = p.last ? 16'd0 : next_count;
    p.pos_x     = x_pos;
    p.pos_y     = y_pos;
    p.heading   = heading_pos;
    return p;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result checker: every output transfer against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_poses.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %h last %b",
                 $time, m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        want_pose = expected_poses.pop_front();
        compare_field("pos_x", want_pose.pos_x, m_axis_tdata[31:0]);
        compare_field("pos_y", want_pose.pos_y, m_axis_tdata[63:32]);
        compare_field("heading", want_pose.heading, m_axis_tdata[95:64]);
        compare_field("last", {31'b0, want_pose.last}, {31'b0, m_axis_tlast});
      end
    end
  end

  // Watchdog on cycles without any transfer on any channel.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // One tick transfer, with an optional sender gap ahead of it.
  task automatic send_tick(input logic restart);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, restart};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_poses.push_back(advance_pose(restart));
  endtask

  // Hold the input back until every result is home, then let the block go quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      upi_pkg::CFG_STEP_LENGTH:    step_len   = data[24:0];
      upi_pkg::CFG_HEADING_STEP:   turn_step  = data;
      upi_pkg::CFG_STEPS_PER_PATH: path_ticks = data[15:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_default_registers();
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  // Path length lowered to the count already reached: the four ticks run on past it without a last.
  task automatic test_path_end();
    settle();
    cfg_write(upi_pkg::CFG_STEPS_PER_PATH, 32'd3);
    repeat (4) send_tick(1'b0);
  endtask

  // Step length with all data bits set (only 25 kept), half-turn heading step,
  // then zero length with the largest positive heading step.
  task automatic test_step_extremes();
    settle();
    cfg_write(upi_pkg::CFG_STEP_LENGTH, 32'hFFFFFFFF);
    cfg_write(upi_pkg::CFG_HEADING_STEP, 32'h80000000);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    settle();
    cfg_write(upi_pkg::CFG_STEP_LENGTH, 32'd0);
    cfg_write(upi_pkg::CFG_HEADING_STEP, 32'h7FFFFFFF);
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  // Quarter-turn steps put the midpoint in each quadrant, folded ones included.
  task automatic test_quadrants();
    settle();
    cfg_write(upi_pkg::CFG_STEP_LENGTH, 32'd16777216);
    cfg_write(upi_pkg::CFG_HEADING_STEP, 32'h40000000);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
  endtask

  task automatic test_spare_index();
    settle();
    cfg_write(CFG_SPARE, $urandom);
    send_tick(1'b0);
  endtask

  // Zero path length never matches soon; a count left above a lowered path
  // length runs on without a last.
  task automatic test_count_wrap();
    settle();
    cfg_write(upi_pkg::CFG_STEPS_PER_PATH, 32'd0);
    send_tick(1'b1);
    send_tick(1'b0);
    settle();
    cfg_write(upi_pkg::CFG_STEPS_PER_PATH, 32'd20);
    repeat (4) send_tick(1'b0);
    settle();
    cfg_write(upi_pkg::CFG_STEPS_PER_PATH, 32'd2);
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  // Random paths: registers redrawn between paths, each path mostly opens
  // with a restart, with the odd stray restart inside it.
  task automatic test_random_paths(input int total);
    int          sent;
    int          path_len;
    logic [31:0] data;
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 47 : 0;
      rx_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 26 : 0;
      sent = 0;
      while (sent < total / 3) begin
        settle();
        if ($urandom_range(0, 1) == 0) begin
          case ($urandom_range(0, 5))
            0:       data = 32'd0;
            1:       data = 32'd16777216;
            2:       data = $urandom;
            default: data = $urandom_range(0, 200000);
          endcase
          cfg_write(upi_pkg::CFG_STEP_LENGTH, data);
        end
        if ($urandom_range(0, 1) == 0) begin
          case ($urandom_range(0, 5))
            0:       data = 32'h80000000;
            1:       data = 32'h7FFFFFFF;
            2:       data = $urandom;
            3:       data = 32'hFFFFFFFF;
            default: data = $urandom_range(0, 32'h04000000) - 32'h02000000;
          endcase
          cfg_write(upi_pkg::CFG_HEADING_STEP, data);
        end
        if ($urandom_range(0, 1) == 0) begin
          data[31:16] = $urandom;
          case ($urandom_range(0, 5))
            0:       data[15:0] = 16'd0;
            1:       data[15:0] = $urandom_range(0, 65535);
            2:       data[15:0] = 16'd1;
            default: data[15:0] = $urandom_range(1, 40);
          endcase
          cfg_write(upi_pkg::CFG_STEPS_PER_PATH, data);
        end
        if ($urandom_range(0, 9) == 0) cfg_write(CFG_SPARE, $urandom);
        path_len = $urandom_range(4, 40);
        for (int k = 0; k < path_len; k++) begin
          send_tick((k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0));
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_registers();
    test_path_end();
    test_step_extremes();
    test_quadrants();
    test_spare_index();
    test_count_wrap();
    test_random_paths(RANDOM_TICKS);
    settle();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/upi_pkg.sv
rtl/upi_cfg.sv
rtl/upi_cordic.sv
rtl/unicycle_pose_integrator_unit.sv
bench/tb.sv
